// File: hdl/tmsr_pkg.sv
`timescale 1ns / 1ps

package tmsr_pkg;

    // Item modes
    localparam logic [1:0] MODE_CELL   = 2'd0;
    localparam logic [1:0] MODE_FONT   = 2'd1;
    localparam logic [1:0] MODE_RENDER = 2'd2;

    // Register indexes
    localparam int         REG_IDX_W   = 1;
    localparam logic [0:0] REG_BLACK   = 1'b0;
    localparam logic [0:0] REG_WHITE   = 1'b1;
    localparam int         CFG_W       = 8;

    localparam logic [7:0] BLACK_RESET = 8'h00;
    localparam logic [7:0] WHITE_RESET = 8'hFF;
    localparam logic [7:0] SPACE_CODE  = 8'h20;

    localparam int         FONT_AW     = 12;
    localparam int         OFFSET_W    = 10;
    localparam logic [9:0] HALF_STEP   = 10'd8;
    localparam int         WORD_W      = 64;

    // Fraction bits of the reciprocal used for the divide by the font height
    localparam int         DIV_SHIFT   = 15;

    typedef struct packed {
        logic       inverse;
        logic [7:0] code;
    } cell_t;

    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

    // Four pixels, bit 3 first, become eight samples, earliest in the low byte.
    function automatic logic [WORD_W-1:0] expand_nibble(input logic [3:0] nib,
                                                        input logic [7:0] white,
                                                        input logic [7:0] black);
        logic [WORD_W-1:0] word;
        logic [7:0]        s;
        word = '0;
        for (int k = 0; k < 4; k++)
        begin
            s = nib[3-k] ? white : black;
            word[16*k +: 8]     = s;
            word[16*k + 8 +: 8] = s;
        end
        return word;
    endfunction

endpackage

// File: hdl/tmsr_cmd_if.sv
`timescale 1ns / 1ps

interface tmsr_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [3:0]  cell_row;
    logic [5:0]  cell_column;
    logic [7:0]  char_code;
    logic [7:0]  cell_attributes;
    logic [11:0] font_address;
    logic [7:0]  font_bits;
    logic [9:0]  scan_line;

    modport source (output valid, mode, cell_row, cell_column, char_code,
                    cell_attributes, font_address, font_bits, scan_line,
                    input ready);
    modport sink (input valid, mode, cell_row, cell_column, char_code,
                  cell_attributes, font_address, font_bits, scan_line,
                  output ready);
endinterface

// File: hdl/tmsr_pix_if.sv
`timescale 1ns / 1ps

interface tmsr_pix_if;
    logic        valid;
    logic        ready;
    logic [9:0]  sample_offset;
    logic [63:0] pixel_samples;
    logic        last;

    modport source (output valid, sample_offset, pixel_samples, last, input ready);
    modport sink (input valid, sample_offset, pixel_samples, last, output ready);
endinterface

// File: hdl/text_mode_scanline_renderer_unit.sv
`timescale 1ns / 1ps

// Text-mode character generator. Cell writes (mode 0) and font writes (mode 1)
// are done at acceptance. A render (mode 2) that lands in the grid goes through
// the divide of the line by the font height, the cell store read, the font store
// read and the load of the output register, in that order, before the next item
// is taken. A render above the top line is dropped at acceptance, and one below
// the text area or right of the grid is dropped after the divide. The load step
// waits until the output register is empty or its second result is taken in
// that cycle. Each render that lands in the grid gives two results, left eight
// samples first; the second is shown in the cycle after the first is taken.
// After reset the cell store is swept to spaces, all COLUMNS*ROWS cells (455 at
// the default size), with cmd.ready low; configuration writes are taken throughout.
module text_mode_scanline_renderer_unit #(
    parameter int COLUMNS     = 35,
    parameter int ROWS        = 13,
    parameter int FONT_LINES  = 16,
    parameter int TOP_LINE    = 10,
    parameter int LEFT_OFFSET = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    tmsr_cmd_if.sink                       cmd,
    tmsr_pix_if.source                     pix,
    input  logic                           cfg_we,
    input  logic [tmsr_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [tmsr_pkg::CFG_W-1:0]     cfg_data
);
    import tmsr_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int CELL_AW    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int RECIP      = ((1 << DIV_SHIFT) + FONT_LINES - 1) / FONT_LINES;
    localparam int RECIP_W    = $clog2(RECIP + 1);
    localparam int REL_W      = 10;
    localparam int PROD_W     = REL_W + RECIP_W;
    localparam int CROW_W     = PROD_W - DIV_SHIFT;

    typedef enum logic [1:0] {ST_IDLE, ST_LOOKUP, ST_CELL, ST_FONT} state_t;

    state_t              state_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [3:0]          rel4_reg;
    logic [5:0]          col_reg;
    logic [3:0]          fline_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic                inv_reg;
    logic [7:0]          black_reg;
    logic [7:0]          white_reg;

    logic                accept;
    logic                line_ok;
    logic [REL_W-1:0]    rel;
    logic [CROW_W-1:0]   crow;
    logic                in_range;
    logic [3:0]          fline;
    logic [CELL_AW-1:0]  render_idx;
    logic [CELL_AW-1:0]  write_idx;
    logic                clearing;
    logic                out_free;
    logic                out_load;
    mem_ctl_t            cell_ctl;
    mem_ctl_t            font_ctl;
    cell_t               cell_wdata;
    cell_t               cell_rdata;
    logic [7:0]          font_rdata;

    assign cmd.ready = (state_reg == ST_IDLE) && !clearing;
    assign accept    = cmd.valid && cmd.ready;

    assign line_ok = cmd.scan_line >= REL_W'(TOP_LINE);
    assign rel     = cmd.scan_line - REL_W'(TOP_LINE);

    // Row and font line of the registered line product
    assign crow       = prod_reg[PROD_W-1:DIV_SHIFT];
    assign fline      = rel4_reg - 4'(crow * FONT_LINES);
    assign in_range   = (crow < CROW_W'(ROWS)) && ({1'b0, col_reg} < 7'(COLUMNS));
    assign render_idx = CELL_AW'(crow * COLUMNS + col_reg);
    assign write_idx  = CELL_AW'(cmd.cell_row * COLUMNS + cmd.cell_column);

    always_comb
    begin
        cell_ctl.we = accept && (cmd.mode == MODE_CELL)
                      && ({1'b0, cmd.cell_row} < 5'(ROWS))
                      && ({1'b0, cmd.cell_column} < 7'(COLUMNS));
        cell_ctl.re = (state_reg == ST_LOOKUP) && in_range;
        font_ctl.we = accept && (cmd.mode == MODE_FONT);
        font_ctl.re = (state_reg == ST_CELL);
        cell_wdata  = '{inverse: cmd.cell_attributes[0], code: cmd.char_code};
    end

    assign out_load = (state_reg == ST_FONT) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            black_reg <= BLACK_RESET;
            white_reg <= WHITE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BLACK: black_reg <= cfg_data;
                REG_WHITE: white_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            prod_reg   <= '0;
            rel4_reg   <= '0;
            col_reg    <= '0;
            fline_reg  <= '0;
            offset_reg <= '0;
            inv_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (cmd.mode == MODE_RENDER) && line_ok)
                    begin
                        prod_reg  <= PROD_W'(rel) * PROD_W'(RECIP);
                        rel4_reg  <= rel[3:0];
                        col_reg   <= cmd.cell_column;
                        state_reg <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP:
                begin
                    fline_reg  <= fline;
                    offset_reg <= OFFSET_W'(LEFT_OFFSET) + {col_reg, 4'b0000};
                    // Drop renders below the text area or right of the grid
                    state_reg  <= in_range ? ST_CELL : ST_IDLE;
                end
                ST_CELL:
                begin
                    inv_reg   <= cell_rdata.inverse;
                    state_reg <= ST_FONT;
                end
                ST_FONT:
                begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    tmsr_cell_store #(
        .CELL_COUNT (CELL_COUNT),
        .CELL_AW    (CELL_AW)
    ) u_cells (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (cell_ctl),
        .waddr    (write_idx),
        .wdata    (cell_wdata),
        .raddr    (render_idx),
        .rdata    (cell_rdata),
        .clearing (clearing)
    );

    tmsr_font_store u_font (
        .clk   (clk),
        .ctl   (font_ctl),
        .waddr (cmd.font_address),
        .wdata (cmd.font_bits),
        .raddr ({cell_rdata.code, fline_reg}),
        .rdata (font_rdata)
    );

    tmsr_out_stage u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (out_load),
        .bits   (font_rdata ^ {8{inv_reg}}),
        .offset (offset_reg),
        .white  (white_reg),
        .black  (black_reg),
        .free   (out_free),
        .pix    (pix)
    );

    a_render_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.mode == MODE_RENDER) && line_ok) |=> (state_reg == ST_LOOKUP))
        else $error("render item not started");
    a_result_from_font: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pix.valid) |-> ($past(state_reg) == ST_FONT))
        else $error("result appeared without a font lookup");
    a_idle_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> (state_reg == ST_IDLE))
        else $error("item in flight during clearing pass");

endmodule

// File: hdl/tmsr_cell_store.sv
`timescale 1ns / 1ps

module tmsr_cell_store #(
    parameter int CELL_COUNT = 455,
    parameter int CELL_AW    = 9
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tmsr_pkg::mem_ctl_t   ctl,
    input  logic [CELL_AW-1:0]   waddr,
    input  tmsr_pkg::cell_t      wdata,
    input  logic [CELL_AW-1:0]   raddr,
    output tmsr_pkg::cell_t      rdata,
    output logic                 clearing
);
    import tmsr_pkg::*;

    cell_t              mem [CELL_COUNT];
    cell_t              rdata_reg;
    logic [CELL_AW-1:0] clear_cnt_reg;
    logic               clearing_reg;

    // Sweep the store with spaces after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
            clearing_reg  <= 1'b1;
        end
        else if (clearing_reg)
        begin
            if (clear_cnt_reg == CELL_AW'(CELL_COUNT - 1))
                clearing_reg <= 1'b0;
            else
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            mem[clear_cnt_reg] <= '{inverse: 1'b0, code: SPACE_CODE};
        else if (ctl.we)
            mem[waddr] <= wdata;
        if (ctl.re)
            rdata_reg <= mem[raddr];
    end

    assign rdata    = rdata_reg;
    assign clearing = clearing_reg;

    a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !ctl.we)
        else $error("cell write during clearing pass");
    a_clear_bound: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> (clear_cnt_reg <= CELL_AW'(CELL_COUNT - 1)))
        else $error("clear counter past end of store");
    a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clearing_reg) |-> ($past(clear_cnt_reg) == CELL_AW'(CELL_COUNT - 1)))
        else $error("clearing pass ended early");

endmodule

// File: hdl/tmsr_font_store.sv
`timescale 1ns / 1ps

module tmsr_font_store (
    input  logic                          clk,
    input  tmsr_pkg::mem_ctl_t            ctl,
    input  logic [tmsr_pkg::FONT_AW-1:0]  waddr,
    input  logic [7:0]                    wdata,
    input  logic [tmsr_pkg::FONT_AW-1:0]  raddr,
    output logic [7:0]                    rdata
);
    import tmsr_pkg::*;

    localparam int FONT_DEPTH = 1 << FONT_AW;

    logic [7:0] mem [FONT_DEPTH];
    logic [7:0] rdata_reg;

    // Read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (ctl.we)
            mem[waddr] <= wdata;
        if (ctl.re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/tmsr_out_stage.sv
`timescale 1ns / 1ps

module tmsr_out_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [7:0]                    bits,
    input  logic [tmsr_pkg::OFFSET_W-1:0] offset,
    input  logic [7:0]                    white,
    input  logic [7:0]                    black,
    output logic                          free,
    tmsr_pix_if.source                    pix
);
    import tmsr_pkg::*;

    logic [WORD_W-1:0]   word0_reg;
    logic [WORD_W-1:0]   word1_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic                half_reg;
    logic                valid_reg;

    // Free once empty or while the second result leaves
    assign free = !valid_reg || (pix.ready && half_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word0_reg  <= '0;
            word1_reg  <= '0;
            offset_reg <= '0;
            half_reg   <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else if (load && free)
        begin
            word0_reg  <= expand_nibble(bits[7:4], white, black);
            word1_reg  <= expand_nibble(bits[3:0], white, black);
            offset_reg <= offset;
            half_reg   <= 1'b0;
            valid_reg  <= 1'b1;
        end
        else if (valid_reg && pix.ready)
        begin
            if (half_reg)
                valid_reg <= 1'b0;
            else
                half_reg <= 1'b1;
        end
    end

    assign pix.valid         = valid_reg;
    assign pix.last          = half_reg;
    assign pix.pixel_samples = half_reg ? word1_reg : word0_reg;
    assign pix.sample_offset = half_reg ? (offset_reg + HALF_STEP) : offset_reg;

    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.ready && !pix.last) |=> (pix.valid && pix.last))
        else $error("second result did not follow the first");
    a_second_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.ready && !pix.last)
            |=> (pix.sample_offset == $past(pix.sample_offset) + HALF_STEP))
        else $error("second result offset wrong");
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !free) |=> $stable(offset_reg))
        else $error("output overwritten while busy");

endmodule

// File: tb/text_mode_scanline_renderer_unit_tb.sv
`timescale 1ns / 1ps

module text_mode_scanline_renderer_unit_tb;
    import tmsr_pkg::*;

    localparam int COLUMNS     = 35;
    localparam int ROWS        = 13;
    localparam int FONT_LINES  = 16;
    localparam int TOP_LINE    = 10;
    localparam int LEFT_OFFSET = 64;
    localparam int CELLS       = COLUMNS * ROWS;
    localparam int TEXT_LINES  = ROWS * FONT_LINES;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  mode;
        logic [3:0]  row;
        logic [5:0]  column;
        logic [7:0]  code;
        logic [7:0]  attr;
        logic [11:0] faddr;
        logic [7:0]  fbits;
        logic [9:0]  line;
    } cmd_item_t;

    typedef struct {
        logic [9:0]  offset;
        logic [63:0] samples;
        logic        last;
    } pix_word_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    tmsr_cmd_if cmd_bus ();
    tmsr_pix_if pix_bus ();

    text_mode_scanline_renderer_unit #(
        .COLUMNS     (COLUMNS),
        .ROWS        (ROWS),
        .FONT_LINES  (FONT_LINES),
        .TOP_LINE    (TOP_LINE),
        .LEFT_OFFSET (LEFT_OFFSET)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_bus),
        .pix       (pix_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state
    logic [7:0] black_lvl;
    logic [7:0] white_lvl;
    logic [7:0] cell_char [CELLS];
    logic [7:0] cell_attr [CELLS];
    logic [7:0] font_line [4096];
    bit         font_valid [4096];

    pix_word_t pending_pixels [$];
    int        errors = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        hold_left = 0;

    function automatic logic [63:0] spread_pixels(input logic [3:0] nib);
        logic [63:0] word;
        logic [7:0]  s;
        word = '0;
        for (int k = 0; k < 4; k++)
        begin
            s = nib[3-k] ? white_lvl : black_lvl;
            word[16*k +: 8]     = s;
            word[16*k + 8 +: 8] = s;
        end
        return word;
    endfunction

    // Font address a render reads, or -1 when the render emits nothing
    function automatic int render_font_addr(input cmd_item_t it);
        int rel;
        int idx;
        if (it.mode != MODE_RENDER || it.line < TOP_LINE)
            return -1;
        rel = int'(it.line) - TOP_LINE;
        if (rel / FONT_LINES >= ROWS || it.column >= COLUMNS)
            return -1;
        idx = (rel / FONT_LINES) * COLUMNS + int'(it.column);
        return (int'(cell_char[idx]) * 16 + rel % FONT_LINES) & 12'hFFF;
    endfunction

    function automatic void predict_item(input cmd_item_t it);
        int        idx;
        int        faddr;
        int        base;
        logic [7:0] bits;
        pix_word_t w;
        case (it.mode)
            MODE_CELL:
            begin
                if (it.row < ROWS && it.column < COLUMNS)
                begin
                    idx = int'(it.row) * COLUMNS + int'(it.column);
                    cell_char[idx] = it.code;
                    cell_attr[idx] = it.attr;
                end
            end
            MODE_FONT:
            begin
                font_line[it.faddr]  = it.fbits;
                font_valid[it.faddr] = 1'b1;
            end
            MODE_RENDER:
            begin
                faddr = render_font_addr(it);
                if (faddr >= 0)
                begin
                    idx  = ((int'(it.line) - TOP_LINE) / FONT_LINES) * COLUMNS + int'(it.column);
                    bits = font_line[faddr];
                    if (cell_attr[idx][0])
                        bits = ~bits;
                    base = LEFT_OFFSET + 16 * int'(it.column);
                    w.offset  = 10'(base);
                    w.samples = spread_pixels(bits[7:4]);
                    w.last    = 1'b0;
                    pending_pixels.push_back(w);
                    w.offset  = 10'(base + 8);
                    w.samples = spread_pixels(bits[3:0]);
                    w.last    = 1'b1;
                    pending_pixels.push_back(w);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic cmd_item_t mk(input logic [1:0] mode, input logic [3:0] row,
                                     input logic [5:0] column, input logic [7:0] code,
                                     input logic [7:0] attr, input logic [11:0] faddr,
                                     input logic [7:0] fbits, input logic [9:0] line);
        cmd_item_t it;
        it.mode   = mode;
        it.row    = row;
        it.column = column;
        it.code   = code;
        it.attr   = attr;
        it.faddr  = faddr;
        it.fbits  = fbits;
        it.line   = line;
        return it;
    endfunction

    function automatic cmd_item_t rand_item();
        return mk(2'($urandom_range(3)), 4'($urandom_range(15)), 6'($urandom_range(63)),
                  8'($urandom_range(255)), 8'($urandom_range(255)),
                  12'($urandom_range(4095)), 8'($urandom_range(255)),
                  10'($urandom_range(1023)));
    endfunction

    task automatic drive_item(input cmd_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_bus.valid           <= 1'b1;
        cmd_bus.mode            <= it.mode;
        cmd_bus.cell_row        <= it.row;
        cmd_bus.cell_column     <= it.column;
        cmd_bus.char_code       <= it.code;
        cmd_bus.cell_attributes <= it.attr;
        cmd_bus.font_address    <= it.faddr;
        cmd_bus.font_bits       <= it.fbits;
        cmd_bus.scan_line       <= it.line;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        predict_item(it);
    endtask

    // A render that would read a never-written font line gets that line written first
    task automatic send_item(input cmd_item_t it);
        int faddr;
        faddr = render_font_addr(it);
        if (faddr >= 0 && !font_valid[faddr])
            drive_item(mk(MODE_FONT, 4'($urandom_range(15)), 6'($urandom_range(63)),
                          8'($urandom_range(255)), 8'($urandom_range(255)),
                          12'(faddr), 8'($urandom_range(255)), 10'($urandom_range(1023))));
        drive_item(it);
    endtask

    // Drop valid, wait until every result is in, then let the pipeline drain
    task automatic settle();
        @(negedge clk);
        cmd_bus.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_BLACK)
            black_lvl = value;
        else
            white_lvl = value;
    endtask

    task automatic set_levels(input logic [7:0] black, input logic [7:0] white);
        write_reg(REG_BLACK, black);
        write_reg(REG_WHITE, white);
    endtask

    task automatic directed_test();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // reset cell is a space with no attributes
        send_item(mk(MODE_FONT, 4'd0, 6'd0, 8'd0, 8'd0, 12'h200, 8'hA5, 10'd0));
        send_item(mk(MODE_RENDER, 4'd0, 6'd0, 8'd0, 8'd0, 12'd0, 8'd0, 10'(TOP_LINE)));
        // last column, inverse, highest font address
        send_item(mk(MODE_CELL, 4'd0, 6'(COLUMNS - 1), 8'hFF, 8'h01, 12'd0, 8'd0, 10'd0));
        send_item(mk(MODE_FONT, 4'd0, 6'd0, 8'd0, 8'd0, 12'hFFF, 8'h81, 10'd0));
        send_item(mk(MODE_RENDER, 4'd0, 6'(COLUMNS - 1), 8'd0, 8'd0, 12'd0, 8'd0,
                     10'(TOP_LINE + FONT_LINES - 1)));
        // last row, last text line
        send_item(mk(MODE_CELL, 4'(ROWS - 1), 6'd0, 8'h00, 8'hFE, 12'd0, 8'd0, 10'd0));
        send_item(mk(MODE_FONT, 4'd0, 6'd0, 8'd0, 8'd0, 12'h00F, 8'hFF, 10'd0));
        send_item(mk(MODE_RENDER, 4'd0, 6'd0, 8'd0, 8'd0, 12'd0, 8'd0,
                     10'(TOP_LINE + TEXT_LINES - 1)));
        send_item(mk(MODE_FONT, 4'd0, 6'd0, 8'd0, 8'd0, 12'h000, 8'h00, 10'd0));
        send_item(mk(MODE_CELL, 4'(ROWS - 1), 6'd1, 8'h00, 8'hFF, 12'd0, 8'd0, 10'd0));
        send_item(mk(MODE_RENDER, 4'd0, 6'd1, 8'd0, 8'd0, 12'd0, 8'd0,
                     10'(TOP_LINE + (ROWS - 1) * FONT_LINES)));
        // cell writes off the grid
        send_item(mk(MODE_CELL, 4'(ROWS), 6'd0, 8'h55, 8'h01, 12'd0, 8'd0, 10'd0));
        send_item(mk(MODE_CELL, 4'd0, 6'(COLUMNS), 8'h55, 8'h01, 12'd0, 8'd0, 10'd0));
        send_item(mk(MODE_CELL, 4'd15, 6'd63, 8'hFF, 8'hFF, 12'hFFF, 8'hFF, 10'h3FF));
        send_item(mk(MODE_RENDER, 4'd0, 6'd0, 8'd0, 8'd0, 12'd0, 8'd0, 10'(TOP_LINE)));
        // renders outside the text area or grid
        send_item(mk(MODE_RENDER, 4'd0, 6'd0, 8'd0, 8'd0, 12'd0, 8'd0, 10'(TOP_LINE - 1)));
        send_item(mk(MODE_RENDER, 4'd0, 6'd0, 8'd0, 8'd0, 12'd0, 8'd0, 10'd0));
        send_item(mk(MODE_RENDER, 4'd0, 6'd0, 8'd0, 8'd0, 12'd0, 8'd0,
                     10'(TOP_LINE + TEXT_LINES)));
        send_item(mk(MODE_RENDER, 4'd15, 6'd63, 8'hFF, 8'hFF, 12'hFFF, 8'hFF, 10'h3FF));
        send_item(mk(MODE_RENDER, 4'd0, 6'(COLUMNS), 8'd0, 8'd0, 12'd0, 8'd0, 10'd100));
        send_item(mk(MODE_UNUSED, 4'd15, 6'd63, 8'hFF, 8'hFF, 12'hFFF, 8'hFF, 10'h3FF));
        send_item(mk(MODE_RENDER, 4'd0, 6'd5, 8'd0, 8'd0, 12'd0, 8'd0, 10'd100));
        settle();
    endtask

    task automatic random_traffic(input int count, input int send_pct, input int recv_pct);
        cmd_item_t it;
        int        pick;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < count; n++)
        begin
            it   = rand_item();
            pick = $urandom_range(99);
            if (pick < 25)
            begin
                it.mode   = MODE_CELL;
                it.row    = 4'($urandom_range(ROWS - 1));
                it.column = 6'($urandom_range(COLUMNS - 1));
            end
            else if (pick < 40)
                it.mode = MODE_FONT;
            else if (pick < 85)
            begin
                it.mode   = MODE_RENDER;
                it.line   = 10'($urandom_range(TOP_LINE + TEXT_LINES - 1, TOP_LINE));
                it.column = 6'($urandom_range(COLUMNS - 1));
            end
            send_item(it);
        end
        settle();
    endtask

    task automatic stall_test(input int count);
        cmd_item_t it;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge clk);
        hold_left = 300;
        for (int n = 0; n < count; n++)
        begin
            it        = rand_item();
            it.mode   = MODE_RENDER;
            it.line   = 10'($urandom_range(TOP_LINE + TEXT_LINES - 1, TOP_LINE));
            it.column = 6'($urandom_range(COLUMNS - 1));
            send_item(it);
        end
        settle();
    endtask

    // Receiver: random back-pressure plus the long hold-off
    initial
    begin
        pix_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                pix_bus.ready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else
                pix_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        pix_word_t w;
        if (pix_bus.valid && pix_bus.ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                errors++;
                $display("%0t result: expected none actual offset %h samples %h last %b",
                         $time, pix_bus.sample_offset, pix_bus.pixel_samples, pix_bus.last);
            end
            else
            begin
                w = pending_pixels.pop_front();
                if (pix_bus.sample_offset !== w.offset)
                begin
                    errors++;
                    $display("%0t sample_offset: expected %h actual %h", $time,
                             w.offset, pix_bus.sample_offset);
                end
                if (pix_bus.pixel_samples !== w.samples)
                begin
                    errors++;
                    $display("%0t pixel_samples: expected %h actual %h", $time,
                             w.samples, pix_bus.pixel_samples);
                end
                if (pix_bus.last !== w.last)
                begin
                    errors++;
                    $display("%0t last: expected %b actual %b", $time, w.last, pix_bus.last);
                end
            end
        end
    end

    initial
    begin
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = '0;
        cfg_data                = '0;
        cmd_bus.valid           = 1'b0;
        cmd_bus.mode            = MODE_CELL;
        cmd_bus.cell_row        = '0;
        cmd_bus.cell_column     = '0;
        cmd_bus.char_code       = '0;
        cmd_bus.cell_attributes = '0;
        cmd_bus.font_address    = '0;
        cmd_bus.font_bits       = '0;
        cmd_bus.scan_line       = '0;
        black_lvl               = BLACK_RESET;
        white_lvl               = WHITE_RESET;
        for (int i = 0; i < CELLS; i++)
        begin
            cell_char[i] = SPACE_CODE;
            cell_attr[i] = 8'h00;
        end
        for (int i = 0; i < 4096; i++)
        begin
            font_line[i]  = 8'h00;
            font_valid[i] = 1'b0;
        end
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        directed_test();
        set_levels(8'h10, 8'hE0);
        random_traffic(260, 38, 77);
        set_levels(8'hFF, 8'h00);
        random_traffic(260, 77, 38);
        set_levels(8'($urandom_range(255)), 8'($urandom_range(255)));
        random_traffic(260, 0, 0);
        set_levels(8'h00, 8'hFF);
        stall_test(40);
        set_levels(8'h5A, 8'h5A);
        random_traffic(20, 20, 20);

        settle();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
